/* design/ray_box_slab_test_macros.svh */
// Assertion macros shared by the ray/box slab test design.
`ifndef RAY_BOX_SLAB_TEST_MACROS_SVH
`define RAY_BOX_SLAB_TEST_MACROS_SVH

// Checks that cond holds in the same cycle as trig.
`define RBS_ASSERT_SAME(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Checks that cond holds in the cycle after trig.
`define RBS_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

/* design/rbs_pkg.sv */
// Types, constants and register codes for the ray/box slab test pipeline.
package rbs_pkg;

    localparam int AXES = 3;

    typedef logic signed [31:0] q16_t;
    typedef logic signed [32:0] diff_t;
    typedef logic signed [63:0] prod_t;

    typedef q16_t  [AXES-1:0] q16_vec_t;
    typedef diff_t [AXES-1:0] diff_vec_t;
    typedef prod_t [AXES-1:0] prod_vec_t;

    localparam q16_t Q16_MAX       = 32'sh7FFF_FFFF;
    localparam q16_t Q16_MIN       = 32'sh8000_0000;
    localparam q16_t BOX_MIN_RESET = 32'sh0000_0000;
    localparam q16_t BOX_MAX_RESET = 32'sh0001_0000;

    typedef enum logic [2:0] {
        CFG_BOX_MIN_X = 3'd0,
        CFG_BOX_MIN_Y = 3'd1,
        CFG_BOX_MIN_Z = 3'd2,
        CFG_BOX_MAX_X = 3'd3,
        CFG_BOX_MAX_Y = 3'd4,
        CFG_BOX_MAX_Z = 3'd5
    } cfg_reg_e;

    typedef struct packed {
        q16_t origin_x;
        q16_t origin_y;
        q16_t origin_z;
        q16_t inv_dir_x;
        q16_t inv_dir_y;
        q16_t inv_dir_z;
        logic neg_x;
        logic neg_y;
        logic neg_z;
        q16_t limit_near;
        q16_t limit_far;
    } ray_in_t;

    typedef struct packed {
        logic hit;
        q16_t entry_distance;
    } result_t;

    // Stage 1: face minus origin for every slab.
    typedef struct packed {
        diff_vec_t d_near;
        diff_vec_t d_far;
        q16_vec_t  inv;
        q16_t      lim_n;
        q16_t      lim_f;
    } st1_t;

    // Stage 2: full products.
    typedef struct packed {
        prod_vec_t p_near;
        prod_vec_t p_far;
        q16_t      lim_n;
        q16_t      lim_f;
    } st2_t;

    // Stage 3: slab parameters back in Q16.16.
    typedef struct packed {
        q16_vec_t t_near;
        q16_vec_t t_far;
        q16_t     lim_n;
        q16_t     lim_f;
    } st3_t;

    // Stage 4: interval after x and y, z slab still pending.
    typedef struct packed {
        q16_t t_in;
        q16_t t_out;
        logic reject;
        q16_t z_near;
        q16_t z_far;
        q16_t lim_n;
        q16_t lim_f;
    } st4_t;

endpackage

/* design/ray_box_slab_test.sv */
// Top level of the ray against axis-aligned box slab test pipeline.
//
//   port group  direction  handshake            payload
//   in_*        input      in_valid / in_stall  rbs_pkg::ray_in_t
//   out_*       output     out_valid/out_stall  rbs_pkg::result_t
//   cfg_*       input      cfg_valid/cfg_ready  cfg_index (3 bits), cfg_data (32 bits)
//
// An accepted item is registered in each stage in turn; one item is taken every cycle while in_stall is low.
// The five register stages are subtract, multiply, scale, x/y merge and z merge with limits.
// Each stage holds its item while the next one is stalled, and a free stage takes a new item
// even while later ones wait, so in_stall is high only when every stage is full and stalled.
// Reset empties the pipeline and loads the box with min 0.0 and max 1.0; cfg_ready is always high.
module ray_box_slab_test (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  rbs_pkg::ray_in_t in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output rbs_pkg::result_t out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [31:0]      cfg_data
);
    import rbs_pkg::*;

    `include "ray_box_slab_test_macros.svh"

    q16_vec_t box_lo_reg;
    q16_vec_t box_hi_reg;

    logic v1;
    logic v2;
    logic v3;
    logic v4;
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    st1_t d1;
    st2_t d2;
    st3_t d3;
    st4_t d4;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_lo_reg <= {AXES{BOX_MIN_RESET}};
            box_hi_reg <= {AXES{BOX_MAX_RESET}};
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_e'(cfg_index))
                CFG_BOX_MIN_X: box_lo_reg[0] <= cfg_data;
                CFG_BOX_MIN_Y: box_lo_reg[1] <= cfg_data;
                CFG_BOX_MIN_Z: box_lo_reg[2] <= cfg_data;
                CFG_BOX_MAX_X: box_hi_reg[0] <= cfg_data;
                CFG_BOX_MAX_Y: box_hi_reg[1] <= cfg_data;
                CFG_BOX_MAX_Z: box_hi_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    rbs_diff u_diff (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (in_valid),
        .up_stall (in_stall),
        .up_data  (in_data),
        .box_lo   (box_lo_reg),
        .box_hi   (box_hi_reg),
        .dn_valid (v1),
        .dn_stall (s1),
        .dn_data  (d1)
    );

    rbs_mult u_mult (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (v1),
        .up_stall (s1),
        .up_data  (d1),
        .dn_valid (v2),
        .dn_stall (s2),
        .dn_data  (d2)
    );

    rbs_scale u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (v2),
        .up_stall (s2),
        .up_data  (d2),
        .dn_valid (v3),
        .dn_stall (s3),
        .dn_data  (d3)
    );

    rbs_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (v3),
        .up_stall (s3),
        .up_data  (d3),
        .dn_valid (v4),
        .dn_stall (s4),
        .dn_data  (d4)
    );

    rbs_result u_result (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (v4),
        .up_stall (s4),
        .up_data  (d4),
        .dn_valid (out_valid),
        .dn_stall (out_stall),
        .dn_data  (out_data)
    );

    // The input stalls only when every stage holds an item and the output is blocked.
    `RBS_ASSERT_SAME(a_stall_only_when_full, clk, rst_n, in_stall,
        v1 && v2 && v3 && v4 && out_valid && out_stall, "input stalled with a free stage")

    // An accepted item always lands in the first stage.
    `RBS_ASSERT_NEXT(a_accept_lands, clk, rst_n, in_valid && !in_stall, v1,
        "accepted item missing from first stage")

    // A stalled product stage keeps its item unchanged.
    `RBS_ASSERT_NEXT(a_mult_holds, clk, rst_n, v2 && s2, v2 && $stable(d2),
        "product stage lost or changed its item while stalled")

endmodule

/* design/rbs_diff.sv */
// First stage: picks the near and far faces per axis and subtracts the origin.
module rbs_diff (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             up_valid,
    output logic             up_stall,
    input  rbs_pkg::ray_in_t up_data,
    input  rbs_pkg::q16_vec_t box_lo,
    input  rbs_pkg::q16_vec_t box_hi,
    output logic             dn_valid,
    input  logic             dn_stall,
    output rbs_pkg::st1_t    dn_data
);
    import rbs_pkg::*;

    logic     valid_reg;
    st1_t     data_reg;
    st1_t     data_next;
    logic     load;
    q16_vec_t org;
    q16_vec_t inv;
    logic [AXES-1:0] neg;
    q16_t     nb;
    q16_t     fb;

    assign load     = !valid_reg || !dn_stall;
    assign up_stall = !load;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    assign org = {up_data.origin_z, up_data.origin_y, up_data.origin_x};
    assign inv = {up_data.inv_dir_z, up_data.inv_dir_y, up_data.inv_dir_x};
    assign neg = {up_data.neg_z, up_data.neg_y, up_data.neg_x};

    always_comb
    begin
        nb        = '0;
        fb        = '0;
        data_next = '0;
        for (int a = 0; a < AXES; a++)
        begin
            nb = neg[a] ? box_hi[a] : box_lo[a];
            fb = neg[a] ? box_lo[a] : box_hi[a];
            data_next.d_near[a] = $signed({nb[31], nb}) - $signed({org[a][31], org[a]});
            data_next.d_far[a]  = $signed({fb[31], fb}) - $signed({org[a][31], org[a]});
        end
        data_next.inv   = inv;
        data_next.lim_n = up_data.limit_near;
        data_next.lim_f = up_data.limit_far;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

/* design/rbs_mult.sv */
// Second stage: six 33x32 signed products, one per slab face.
module rbs_mult (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          up_valid,
    output logic          up_stall,
    input  rbs_pkg::st1_t up_data,
    output logic          dn_valid,
    input  logic          dn_stall,
    output rbs_pkg::st2_t dn_data
);
    import rbs_pkg::*;

    logic              valid_reg;
    st2_t              data_reg;
    st2_t              data_next;
    logic              load;
    logic signed [64:0] pn [AXES];
    logic signed [64:0] pf [AXES];

    assign load     = !valid_reg || !dn_stall;
    assign up_stall = !load;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_comb
    begin
        data_next = '0;
        for (int a = 0; a < AXES; a++)
        begin
            pn[a] = $signed(up_data.d_near[a]) * $signed(up_data.inv[a]);
            pf[a] = $signed(up_data.d_far[a]) * $signed(up_data.inv[a]);
            // The magnitude stays below 2^63, so the top bit is only sign.
            data_next.p_near[a] = pn[a][63:0];
            data_next.p_far[a]  = pf[a][63:0];
        end
        data_next.lim_n = up_data.lim_n;
        data_next.lim_f = up_data.lim_f;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

/* design/rbs_scale.sv */
// Third stage: drops 16 fraction bits (rounding down) and saturates to 32 bits.
module rbs_scale (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          up_valid,
    output logic          up_stall,
    input  rbs_pkg::st2_t up_data,
    output logic          dn_valid,
    input  logic          dn_stall,
    output rbs_pkg::st3_t dn_data
);
    import rbs_pkg::*;

    logic valid_reg;
    st3_t data_reg;
    st3_t data_next;
    logic load;

    assign load     = !valid_reg || !dn_stall;
    assign up_stall = !load;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    // Taking the upper bits of a two's complement word is a floor division.
    function automatic q16_t sat_shift(input prod_t p);
        logic [47:0] sh;
        sh = p[63:16];
        if (sh[47:31] == {17{sh[47]}})
        begin
            sat_shift = sh[31:0];
        end
        else
        begin
            sat_shift = sh[47] ? Q16_MIN : Q16_MAX;
        end
    endfunction

    always_comb
    begin
        data_next = '0;
        for (int a = 0; a < AXES; a++)
        begin
            data_next.t_near[a] = sat_shift(up_data.p_near[a]);
            data_next.t_far[a]  = sat_shift(up_data.p_far[a]);
        end
        data_next.lim_n = up_data.lim_n;
        data_next.lim_f = up_data.lim_f;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

/* design/rbs_merge.sv */
// Fourth stage: intersects the x and y slabs and flags disjoint ones.
module rbs_merge (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          up_valid,
    output logic          up_stall,
    input  rbs_pkg::st3_t up_data,
    output logic          dn_valid,
    input  logic          dn_stall,
    output rbs_pkg::st4_t dn_data
);
    import rbs_pkg::*;

    logic valid_reg;
    st4_t data_reg;
    st4_t data_next;
    logic load;
    q16_t xn;
    q16_t xf;
    q16_t yn;
    q16_t yf;

    assign load     = !valid_reg || !dn_stall;
    assign up_stall = !load;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    assign xn = up_data.t_near[0];
    assign xf = up_data.t_far[0];
    assign yn = up_data.t_near[1];
    assign yf = up_data.t_far[1];

    always_comb
    begin
        data_next        = '0;
        data_next.reject = ($signed(xn) > $signed(yf)) || ($signed(yn) > $signed(xf));
        data_next.t_in   = ($signed(yn) > $signed(xn)) ? yn : xn;
        data_next.t_out  = ($signed(yf) < $signed(xf)) ? yf : xf;
        data_next.z_near = up_data.t_near[2];
        data_next.z_far  = up_data.t_far[2];
        data_next.lim_n  = up_data.lim_n;
        data_next.lim_f  = up_data.lim_f;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

/* design/rbs_result.sv */
// Last stage: folds in the z slab, applies the limits and holds the result item.
module rbs_result (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             up_valid,
    output logic             up_stall,
    input  rbs_pkg::st4_t    up_data,
    output logic             dn_valid,
    input  logic             dn_stall,
    output rbs_pkg::result_t dn_data
);
    import rbs_pkg::*;

    logic    valid_reg;
    result_t data_reg;
    result_t data_next;
    logic    load;
    logic    reject;
    q16_t    t_in;
    q16_t    t_out;

    assign load     = !valid_reg || !dn_stall;
    assign up_stall = !load;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_comb
    begin
        reject = up_data.reject
                 || ($signed(up_data.t_in) > $signed(up_data.z_far))
                 || ($signed(up_data.z_near) > $signed(up_data.t_out));
        t_in  = ($signed(up_data.z_near) > $signed(up_data.t_in)) ? up_data.z_near
                                                                  : up_data.t_in;
        t_out = ($signed(up_data.z_far) < $signed(up_data.t_out)) ? up_data.z_far
                                                                  : up_data.t_out;
        data_next = '0;
        // A disjoint pair of slabs reports a miss at distance zero.
        if (!reject)
        begin
            data_next.hit = ($signed(up_data.lim_n) < $signed(t_out))
                            && ($signed(t_in) < $signed(up_data.lim_f));
            data_next.entry_distance = t_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

/* tb/ray_box_slab_test_test.sv */
// Self-checking testbench for the ray against axis-aligned box slab test pipeline.
module ray_box_slab_test_test;

    timeunit 1ns;
    timeprecision 1ps;

    import rbs_pkg::*;

    localparam q16_t ONE        = 32'sh0001_0000;
    localparam q16_t HALF       = 32'sh0000_8000;
    localparam int   IDLE_LIMIT = 2000;
    localparam int   HOLD_OFF   = 60;
    localparam int   DRAIN_WAIT = 8;
    localparam int   PHASES     = 7;
    localparam int   PHASE_RAYS = 215;

    // Keeps a copy of the box, predicts the slab test for every accepted ray
    // and checks results in order.
    class slab_scoreboard;
        q16_t    box_lo[AXES];
        q16_t    box_hi[AXES];
        result_t expected_hits[$];
        int      errors;
        int      accepted;

        function new();
            for (int a = 0; a < AXES; a++)
            begin
                box_lo[a] = BOX_MIN_RESET;
                box_hi[a] = BOX_MAX_RESET;
            end
            errors   = 0;
            accepted = 0;
        endfunction

        function void set_reg(cfg_reg_e idx, q16_t value);
            case (idx)
                CFG_BOX_MIN_X: box_lo[0] = value;
                CFG_BOX_MIN_Y: box_lo[1] = value;
                CFG_BOX_MIN_Z: box_lo[2] = value;
                CFG_BOX_MAX_X: box_hi[0] = value;
                CFG_BOX_MAX_Y: box_hi[1] = value;
                CFG_BOX_MAX_Z: box_hi[2] = value;
                default: ;
            endcase
        endfunction

        // (bound - origin) * inv, floored back to Q16.16 and saturated.
        function q16_t slab_param(q16_t bound, q16_t org, q16_t inv);
            longint diff;
            longint prod;
            longint scaled;
            diff   = longint'(bound) - longint'(org);
            prod   = diff * longint'(inv);
            scaled = prod >>> 16;
            if (scaled > longint'(Q16_MAX))
                scaled = longint'(Q16_MAX);
            if (scaled < longint'(Q16_MIN))
                scaled = longint'(Q16_MIN);
            return q16_t'(scaled);
        endfunction

        function result_t slab_result(ray_in_t r);
            q16_t    org[AXES];
            q16_t    inv[AXES];
            logic    neg[AXES];
            q16_t    t_in;
            q16_t    t_out;
            q16_t    n;
            q16_t    f;
            result_t res;
            org = '{r.origin_x, r.origin_y, r.origin_z};
            inv = '{r.inv_dir_x, r.inv_dir_y, r.inv_dir_z};
            neg = '{r.neg_x, r.neg_y, r.neg_z};
            t_in  = '0;
            t_out = '0;
            res   = '0;
            for (int a = 0; a < AXES; a++)
            begin
                n = slab_param(neg[a] ? box_hi[a] : box_lo[a], org[a], inv[a]);
                f = slab_param(neg[a] ? box_lo[a] : box_hi[a], org[a], inv[a]);
                if (a == 0)
                begin
                    t_in  = n;
                    t_out = f;
                end
                else
                begin
                    // Disjoint slabs end the test with a miss and zero distance.
                    if (t_in > f || n > t_out)
                        return res;
                    if (n > t_in)
                        t_in = n;
                    if (f < t_out)
                        t_out = f;
                end
            end
            res.hit            = (r.limit_near < t_out) && (t_in < r.limit_far);
            res.entry_distance = t_in;
            return res;
        endfunction

        function void note_ray(ray_in_t r);
            expected_hits.push_back(slab_result(r));
            accepted++;
        endfunction

        function int pending();
            return expected_hits.size();
        endfunction

        task report(string msg);
            if (errors < 100)
                $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(result_t got);
            result_t want;
            if (expected_hits.size() == 0)
            begin
                report("result arrived with no item outstanding");
                return;
            end
            want = expected_hits.pop_front();
            if (got.hit !== want.hit)
                report($sformatf("hit got %b expected %b", got.hit, want.hit));
            if (got.entry_distance !== want.entry_distance)
                report($sformatf("entry_distance got %h expected %h",
                                 got.entry_distance, want.entry_distance));
        endtask
    endclass

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    ray_in_t     in_data   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    result_t     out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    slab_scoreboard sb;
    int             idle_cycles = 0;

    ray_box_slab_test u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic q16_t sat_q16(longint v);
        if (v > longint'(Q16_MAX))
            return Q16_MAX;
        if (v < longint'(Q16_MIN))
            return Q16_MIN;
        return q16_t'(v);
    endfunction

    function automatic ray_in_t mk_ray(q16_t ox, q16_t oy, q16_t oz,
                                       q16_t ix, q16_t iy, q16_t iz,
                                       logic nx, logic ny, logic nz,
                                       q16_t lim_n, q16_t lim_f);
        ray_in_t r;
        r.origin_x   = ox;
        r.origin_y   = oy;
        r.origin_z   = oz;
        r.inv_dir_x  = ix;
        r.inv_dir_y  = iy;
        r.inv_dir_z  = iz;
        r.neg_x      = nx;
        r.neg_y      = ny;
        r.neg_z      = nz;
        r.limit_near = lim_n;
        r.limit_far  = lim_f;
        return r;
    endfunction

    // Mostly rays aimed near the current box, with sign bits that mostly match the direction;
    // the rest are raw random items.
    function automatic ray_in_t random_ray();
        q16_t   org[AXES];
        q16_t   inv[AXES];
        logic   neg[AXES];
        longint lo;
        longint hi;
        longint span;
        longint tgt;
        longint dir;
        int     shift;
        q16_t   lim_n;
        q16_t   lim_f;
        if ($urandom_range(0, 3) == 0)
            return mk_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), $urandom, $urandom);
        for (int a = 0; a < AXES; a++)
        begin
            lo = longint'(sb.box_lo[a]);
            hi = longint'(sb.box_hi[a]);
            if (lo > hi)
            begin
                span = lo;
                lo   = hi;
                hi   = span;
            end
            span = hi - lo;
            // Target somewhat beyond the box too, so misses stay common.
            tgt = lo - span / 4 + longint'({$urandom, $urandom} >> 1) % (span + span / 2 + 1);
            shift = $urandom_range(0, 26);
            dir = longint'($urandom_range(1, 1 << shift));
            if ($urandom_range(0, 1) == 1)
                dir = -dir;
            org[a] = sat_q16(tgt - dir);
            inv[a] = sat_q16((longint'(1) <<< 32) / dir);
            neg[a] = inv[a][31];
            if ($urandom_range(0, 19) == 0)
                neg[a] = ~neg[a];
        end
        lim_n = sat_q16(-longint'($urandom_range(0, 2 * ONE)));
        lim_f = ($urandom_range(0, 9) == 0) ? Q16_MAX : q16_t'($urandom_range(0, 64 * ONE));
        return mk_ray(org[0], org[1], org[2], inv[0], inv[1], inv[2],
                      neg[0], neg[1], neg[2], lim_n, lim_f);
    endfunction

    task automatic send_ray(input ray_in_t r);
        in_valid <= 1'b1;
        in_data  <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_ray(r);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_box(input q16_t lo[AXES], input q16_t hi[AXES]);
        cfg_reg_e idx;
        q16_t     value;
        for (int i = 0; i < 2 * AXES; i++)
        begin
            idx   = cfg_reg_e'(i);
            value = (i < AXES) ? lo[i] : hi[i - AXES];
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= value;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            sb.set_reg(idx, value);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic run_directed();
        // Unit box from reset. Covers hits, rejects on each later axis,
        // sign bits against the direction, strict limit edges and extremes.
        send_ray(mk_ray(-ONE, HALF, HALF, ONE, Q16_MAX, Q16_MAX, 0, 0, 0, 0, Q16_MAX));
        send_ray(mk_ray(-ONE, 2 * ONE, HALF, ONE, Q16_MAX, Q16_MAX, 0, 0, 0, 0, Q16_MAX));
        send_ray(mk_ray(-ONE, HALF, 2 * ONE, ONE, Q16_MAX, Q16_MAX, 0, 0, 0, 0, Q16_MAX));
        send_ray(mk_ray(2 * ONE, HALF, HALF, -ONE, Q16_MAX, Q16_MAX, 1, 0, 0, 0, Q16_MAX));
        send_ray(mk_ray(2 * ONE, HALF, HALF, -ONE, Q16_MAX, Q16_MAX, 0, 0, 0, 0, Q16_MAX));
        send_ray(mk_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, Q16_MIN, Q16_MAX));
        send_ray(mk_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_ray(mk_ray(HALF, HALF, HALF, ONE, ONE, ONE, 0, 0, 0, 0, Q16_MAX));
        send_ray(mk_ray(-ONE, HALF, HALF, ONE, Q16_MAX, Q16_MAX, 0, 0, 0, 2 * ONE, Q16_MAX));
        send_ray(mk_ray(-ONE, HALF, HALF, ONE, Q16_MAX, Q16_MAX, 0, 0, 0, 0, ONE));
        send_ray(mk_ray(Q16_MIN, Q16_MIN, Q16_MIN, Q16_MIN, Q16_MIN, Q16_MIN,
                        1, 1, 1, Q16_MIN, Q16_MIN));
        send_ray(mk_ray(Q16_MAX, Q16_MAX, Q16_MAX, Q16_MAX, Q16_MAX, Q16_MAX,
                        1, 1, 1, Q16_MAX, Q16_MAX));
        send_ray(mk_ray(Q16_MAX, Q16_MAX, Q16_MAX, Q16_MIN, Q16_MIN, Q16_MIN,
                        0, 0, 0, Q16_MIN, Q16_MAX));
        send_ray(mk_ray(Q16_MIN, Q16_MIN, Q16_MIN, Q16_MAX, Q16_MAX, Q16_MAX,
                        1, 1, 1, Q16_MIN, Q16_MAX));
        // Tiny negative product checks that the shift floors.
        send_ray(mk_ray(HALF, HALF, HALF, -1, -1, -1, 1, 1, 1, Q16_MIN, Q16_MAX));
        send_ray(mk_ray(-ONE, HALF, HALF, ONE, Q16_MAX, Q16_MAX, 0, 0, 0, Q16_MIN, Q16_MIN));
    endtask

    task automatic run_random(input int count);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 30);
            repeat (burst)
            begin
                if (sent < count)
                begin
                    send_ray(random_ray());
                    sent++;
                end
            end
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap)
                    @(posedge clk);
            end
        end
    endtask

    initial
    begin : stimulus
        q16_t lo[AXES];
        q16_t hi[AXES];
        sb = new();
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        drain();
        for (int ph = 0; ph < PHASES; ph++)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                case (ph)
                    0:
                    begin
                        lo[a] = Q16_MIN;
                        hi[a] = Q16_MAX;
                    end
                    1:
                    begin
                        // Inverted box.
                        lo[a] = Q16_MAX;
                        hi[a] = Q16_MIN;
                    end
                    PHASES - 1:
                    begin
                        lo[a] = $urandom;
                        hi[a] = $urandom;
                    end
                    default:
                    begin
                        lo[a] = sat_q16(longint'($urandom_range(0, 1 << 25)) - (1 << 24));
                        hi[a] = ($urandom_range(0, 7) == 0) ? lo[a] :
                                sat_q16(longint'(lo[a]) + $urandom_range(0, 1 << 22));
                    end
                endcase
            end
            write_box(lo, hi);
            run_random(PHASE_RAYS);
            drain();
        end
        repeat (DRAIN_WAIT)
            @(posedge clk);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Output side: random stall mixes, plus one long hold-off so the
    // pipeline fills and pushes back on the input.
    initial
    begin : receiver
        int  run;
        int  pct;
        bit  held;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && sb.accepted >= 400)
            begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_OFF)
                    @(posedge clk);
            end
            run = $urandom_range(5, 60);
            case ($urandom_range(0, 3))
                0: pct = 0;
                1: pct = 20;
                2: pct = 50;
                default: pct = 85;
            endcase
            repeat (run)
            begin
                // Start the hold-off as soon as the count is reached, while items still flow.
                if (!held && sb.accepted >= 400)
                    break;
                out_stall <= ($urandom_range(0, 99) < pct);
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

/* sim.f */
+incdir+design
design/rbs_pkg.sv
design/rbs_diff.sv
design/rbs_mult.sv
design/rbs_scale.sv
design/rbs_merge.sv
design/rbs_result.sv
design/ray_box_slab_test.sv
tb/ray_box_slab_test_test.sv
